// ===== src/mtgi_pkg.sv =====
// Shared types, constants and codes for the masked trilinear grid interpolator.
// Depends on nothing; every other file of the block but mtgi_ram imports it.
package mtgi_pkg;

  // Default number of points per axis.
  localparam int MTGI_AXIS_POINTS = 16;

  // Fixed-point format: values are signed Q7.16, weights unsigned Q1.16.
  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = 24;
  localparam int WGT_W     = FRAC_BITS + 1;
  localparam int CNT_W     = 5;
  localparam int CFG_IDX_W = 2;

  // Shared serial divider sizes and accumulator width.
  localparam int DIV_NUM_W = 42;
  localparam int DIV_DEN_W = VAL_W + 1;
  localparam int ACC_W     = DIV_NUM_W;

  localparam logic [WGT_W-1:0]        W_ONE   = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_AXIS_WR = 2'd0,
    OP_GRID_WR = 2'd1,
    OP_QUERY   = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AXIS1_COUNT = 2'd0,
    CFG_AXIS2_COUNT = 2'd1,
    CFG_AXIS3_COUNT = 2'd2
  } cfg_idx_t;

  // One input request.
  typedef struct packed {
    logic [1:0]              operation;
    logic [1:0]              axis_select;
    logic [3:0]              axis_index;
    logic signed [VAL_W-1:0] axis_value;
    logic [3:0]              grid_i1;
    logic [3:0]              grid_i2;
    logic [3:0]              grid_i3;
    logic signed [VAL_W-1:0] grid_value;
    logic                    grid_populated;
    logic signed [VAL_W-1:0] query_x1;
    logic signed [VAL_W-1:0] query_x2;
    logic signed [VAL_W-1:0] query_x3;
  } item_t;

  // One result.
  typedef struct packed {
    logic signed [VAL_W-1:0] interp_value;
    logic                    interp_ok;
    logic [WGT_W-1:0]        weight_total;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr;
    logic take;
    logic ax_start;
    logic scan_chk;
    logic lo_rd;
    logic hi_rd;
    logic hi_take;
    logic t_eval;
    logic t_take;
    logic ax_next;
    logic w12;
    logic w;
    logic mul;
    logic sum;
    logic norm;
    logic result_take;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic is_query;
    logic single;
    logic scan_done;
    logic t_trivial;
    logic div_busy;
    logic ax_last;
    logic corner_last;
    logic wsum_zero;
    logic out_free;
  } status_t;

endpackage

// ===== src/mtgi_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
module mtgi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/mtgi_divider.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on mtgi_pkg for the operand widths.
module mtgi_divider import mtgi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] dividend,
  input  logic [DIV_DEN_W-1:0] divisor,
  output logic                 busy,
  output logic [DIV_NUM_W-1:0] quotient
);

  localparam int CW = $clog2(DIV_NUM_W);

  logic [CW-1:0]        cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_DEN_W:0]   shifted;
  logic                 fits;

  // Partial remainder with the next dividend bit shifted in.
  always_comb begin
    shifted = {rem, quotient[DIV_NUM_W-1]};
    fits    = (shifted >= {1'b0, den});
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(DIV_NUM_W - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      den      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= DIV_DEN_W'(shifted - {1'b0, den});
      end else begin
        rem <= shifted[DIV_DEN_W-1:0];
      end
      quotient <= {quotient[DIV_NUM_W-2:0], fits};
    end
  end

endmodule

// ===== src/mtgi_ctrl.sv =====
// Controller state machine: sequences clearing, searches, divisions and corner sums.
// Depends on mtgi_pkg for the command and status structs.
module mtgi_ctrl import mtgi_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  status_t sts,
  output cmd_t    cmd
);

  typedef enum logic [16:0] {
    S_CLEAR    = 17'h00001,
    S_IDLE     = 17'h00002,
    S_AX_START = 17'h00004,
    S_SCAN_RD  = 17'h00008,
    S_SCAN_CHK = 17'h00010,
    S_LO_RD    = 17'h00020,
    S_HI_RD    = 17'h00040,
    S_HI_TAKE  = 17'h00080,
    S_T_EVAL   = 17'h00100,
    S_T_DIV    = 17'h00200,
    S_AX_NEXT  = 17'h00400,
    S_W12      = 17'h00800,
    S_W        = 17'h01000,
    S_MUL      = 17'h02000,
    S_SUM      = 17'h04000,
    S_NORM     = 17'h08000,
    S_NDIV     = 17'h10000
  } state_t;

  state_t state, state_next;

  // A request is taken only in idle with room for its result.
  assign item_stall = !((state == S_IDLE) && sts.out_free);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (item_valid && sts.out_free) begin
          cmd.take = 1'b1;
          if (sts.is_query) state_next = S_AX_START;
        end
      end
      S_AX_START: begin
        cmd.ax_start = 1'b1;
        state_next   = sts.single ? S_AX_NEXT : S_SCAN_RD;
      end
      S_SCAN_RD: begin
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd.scan_chk = 1'b1;
        state_next   = sts.scan_done ? S_LO_RD : S_SCAN_RD;
      end
      S_LO_RD: begin
        cmd.lo_rd  = 1'b1;
        state_next = S_HI_RD;
      end
      S_HI_RD: begin
        cmd.hi_rd  = 1'b1;
        state_next = S_HI_TAKE;
      end
      S_HI_TAKE: begin
        cmd.hi_take = 1'b1;
        state_next  = S_T_EVAL;
      end
      S_T_EVAL: begin
        cmd.t_eval = 1'b1;
        state_next = sts.t_trivial ? S_AX_NEXT : S_T_DIV;
      end
      S_T_DIV: begin
        if (!sts.div_busy) begin
          cmd.t_take = 1'b1;
          state_next = S_AX_NEXT;
        end
      end
      S_AX_NEXT: begin
        cmd.ax_next = 1'b1;
        state_next  = sts.ax_last ? S_W12 : S_AX_START;
      end
      S_W12: begin
        cmd.w12    = 1'b1;
        state_next = S_W;
      end
      S_W: begin
        cmd.w      = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = sts.corner_last ? S_NORM : S_W12;
      end
      S_NORM: begin
        if (sts.out_free) begin
          cmd.norm   = 1'b1;
          state_next = sts.wsum_zero ? S_IDLE : S_NDIV;
        end
      end
      S_NDIV: begin
        if (!sts.div_busy && sts.out_free) begin
          cmd.result_take = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/mtgi_datapath.sv =====
// Datapath: axis and grid memories, bracket registers, weight arithmetic,
// accumulator, shared divider and result register. Depends on mtgi_pkg,
// mtgi_ram and mtgi_divider.
module mtgi_datapath import mtgi_pkg::*; #(
  parameter int AXIS_POINTS = MTGI_AXIS_POINTS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  item_t                item,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data,
  input  cmd_t                 cmd,
  output status_t              sts,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result
);

  localparam int IW         = (AXIS_POINTS > 1) ? $clog2(AXIS_POINTS) : 1;
  localparam int AX_DEPTH   = 3 * (2 ** IW);
  localparam int AX_AW      = IW + 2;
  localparam int GRID_AW    = 3 * IW;
  localparam int GRID_DEPTH = 2 ** GRID_AW;
  localparam logic [7:0] AP8 = 8'(AXIS_POINTS);

  // Configuration registers.
  logic [CNT_W-1:0] cnt [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt[0] <= CNT_W'(1);
      cnt[1] <= CNT_W'(1);
      cnt[2] <= CNT_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_AXIS1_COUNT: cnt[0] <= cfg_data;
        CFG_AXIS2_COUNT: cnt[1] <= cfg_data;
        CFG_AXIS3_COUNT: cnt[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Write decode for the incoming request.
  logic axis_wr_ok, grid_wr_ok;

  always_comb begin
    axis_wr_ok = (item.operation == OP_AXIS_WR) && (item.axis_select < 2'd3) &&
                 (8'(item.axis_index) < AP8);
    grid_wr_ok = (item.operation == OP_GRID_WR) && (8'(item.grid_i1) < AP8) &&
                 (8'(item.grid_i2) < AP8) && (8'(item.grid_i3) < AP8);
  end

  // Query state and per-axis brackets.
  logic signed [VAL_W-1:0] qx [3];
  logic [1:0]              ax;
  logic [IW-1:0]           scan_i;
  logic [IW-1:0]           lo_r [3];
  logic [IW-1:0]           hi_r [3];
  logic [WGT_W-1:0]        t_r [3];
  logic signed [VAL_W-1:0] alo, ahi;

  logic signed [VAL_W-1:0] qx_cur;
  logic [7:0]              c8, n8;
  logic [IW-1:0]           n_last;

  // Effective point count of the current axis, clamped to one..AXIS_POINTS.
  always_comb begin
    qx_cur = qx[ax];
    c8     = 8'(cnt[ax]);
    if (c8 == 8'd0) begin
      n8 = 8'd1;
    end else if (c8 > AP8) begin
      n8 = AP8;
    end else begin
      n8 = c8;
    end
    n_last = IW'(n8 - 8'd1);
  end

  // Axis table memory.
  logic              ax_we;
  logic [AX_AW-1:0]  ax_waddr, ax_raddr;
  logic [VAL_W-1:0]  ax_rdata;
  logic signed [VAL_W-1:0] ax_rd;

  always_comb begin
    ax_we    = cmd.take && axis_wr_ok;
    ax_waddr = {item.axis_select, IW'(item.axis_index)};
    if (cmd.lo_rd) begin
      ax_raddr = {ax, lo_r[ax]};
    end else if (cmd.hi_rd) begin
      ax_raddr = {ax, hi_r[ax]};
    end else begin
      ax_raddr = {ax, scan_i};
    end
    ax_rd = $signed(ax_rdata);
  end

  mtgi_ram #(
    .WIDTH (VAL_W),
    .DEPTH (AX_DEPTH)
  ) u_axis_ram (
    .clk   (clk),
    .we    (ax_we),
    .waddr (ax_waddr),
    .wdata (item.axis_value),
    .raddr (ax_raddr),
    .rdata (ax_rdata)
  );

  // Upper-bound search step and bracket weight operands.
  logic                    scan_done;
  logic signed [VAL_W:0]   num, den;
  logic                    t_trivial;
  logic [WGT_W-1:0]        t_triv;

  always_comb begin
    scan_done = (ax_rd > qx_cur) || (scan_i == n_last);
    num       = {qx_cur[VAL_W-1], qx_cur} - {alo[VAL_W-1], alo};
    den       = {ahi[VAL_W-1], ahi} - {alo[VAL_W-1], alo};
    t_trivial = (den <= 0) || (num <= 0) || (num >= den);
    t_triv    = ((den <= 0) || (num <= 0)) ? '0 : W_ONE;
  end

  // Corner state.
  logic [2:0]              c;
  logic [WGT_W-1:0]        w1, w2, w3, w12, w;
  logic [2*WGT_W-1:0]      p12, p3;
  logic signed [ACC_W-1:0] prod, acc;
  logic                    use_r;
  logic [WGT_W-1:0]        wsum;
  logic                    neg_r;

  always_comb begin
    w1  = c[2] ? t_r[0] : WGT_W'(W_ONE - t_r[0]);
    w2  = c[1] ? t_r[1] : WGT_W'(W_ONE - t_r[1]);
    w3  = c[0] ? t_r[2] : WGT_W'(W_ONE - t_r[2]);
    p12 = w1 * w2;
    p3  = w12 * w3;
  end

  // Grid memory: populated mark over the value; clearing pass writes the mark low.
  logic [GRID_AW-1:0]  clr_addr;
  logic                g_we;
  logic [GRID_AW-1:0]  g_waddr, g_raddr;
  logic [VAL_W:0]      g_wdata, g_rdata;

  always_comb begin
    g_we    = cmd.clr || (cmd.take && grid_wr_ok);
    g_waddr = cmd.clr ? clr_addr :
              {IW'(item.grid_i1), IW'(item.grid_i2), IW'(item.grid_i3)};
    g_wdata = cmd.clr ? '0 : {item.grid_populated, item.grid_value};
    g_raddr = {c[2] ? hi_r[0] : lo_r[0], c[1] ? hi_r[1] : lo_r[1],
               c[0] ? hi_r[2] : lo_r[2]};
  end

  mtgi_ram #(
    .WIDTH (VAL_W + 1),
    .DEPTH (GRID_DEPTH)
  ) u_grid_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  // Clearing pass address.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Normalization operands.
  logic                 neg;
  logic [ACC_W-1:0]     mag, ndiv;

  always_comb begin
    neg  = acc[ACC_W-1];
    mag  = neg ? ACC_W'(-acc) : ACC_W'(acc);
    ndiv = mag + ACC_W'(wsum >> 1);
  end

  // Shared divider for bracket weights and normalization.
  logic                 div_start, div_busy;
  logic [DIV_NUM_W-1:0] div_num, quo;
  logic [DIV_DEN_W-1:0] div_den;

  always_comb begin
    div_start = (cmd.t_eval && !t_trivial) || (cmd.norm && (wsum != '0));
    if (cmd.t_eval) begin
      div_num = DIV_NUM_W'({num[VAL_W-1:0], {FRAC_BITS{1'b0}}});
      div_den = DIV_DEN_W'(den);
    end else begin
      div_num = ndiv;
      div_den = DIV_DEN_W'(wsum);
    end
  end

  mtgi_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .busy     (div_busy),
    .quotient (quo)
  );

  // Control counters of the query.
  always_ff @(posedge clk) begin
    if (rst) begin
      ax     <= '0;
      scan_i <= '0;
      c      <= '0;
    end else begin
      if (cmd.take) begin
        ax <= '0;
        c  <= '0;
      end else if (cmd.ax_next && (ax != 2'd2)) begin
        ax <= ax + 1'b1;
      end else if (cmd.sum) begin
        c <= c + 1'b1;
      end
      if (cmd.ax_start) begin
        scan_i <= '0;
      end else if (cmd.scan_chk && !scan_done) begin
        scan_i <= scan_i + 1'b1;
      end
    end
  end

  // Query payload, brackets and weights.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      qx[0] <= item.query_x1;
      qx[1] <= item.query_x2;
      qx[2] <= item.query_x3;
      acc   <= '0;
      wsum  <= '0;
    end
    if (cmd.ax_start && (n8 <= 8'd1)) begin
      lo_r[ax] <= '0;
      hi_r[ax] <= '0;
      t_r[ax]  <= '0;
    end
    if (cmd.scan_chk && scan_done) begin
      hi_r[ax] <= (scan_i == '0) ? IW'(1) : scan_i;
      lo_r[ax] <= (scan_i == '0) ? '0 : scan_i - 1'b1;
    end
    if (cmd.hi_rd) alo <= ax_rd;
    if (cmd.hi_take) ahi <= ax_rd;
    if (cmd.t_eval && t_trivial) t_r[ax] <= t_triv;
    if (cmd.t_take) t_r[ax] <= quo[WGT_W-1:0];
    if (cmd.w12) w12 <= p12[FRAC_BITS +: WGT_W];
    if (cmd.w) w <= p3[FRAC_BITS +: WGT_W];
    if (cmd.mul) begin
      prod  <= $signed({1'b0, w}) * $signed(g_rdata[VAL_W-1:0]);
      use_r <= (w != '0) && g_rdata[VAL_W];
    end
    if (cmd.sum && use_r) begin
      acc  <= acc + prod;
      wsum <= wsum + w;
    end
    if (cmd.norm) neg_r <= neg;
  end

  // Result selection.
  logic    res_load;
  result_t res_next;

  always_comb begin
    res_next = '0;
    res_load = 1'b0;
    if (cmd.take && (item.operation != OP_QUERY)) begin
      res_load           = 1'b1;
      res_next.interp_ok = axis_wr_ok || grid_wr_ok;
    end else if (cmd.norm && (wsum == '0)) begin
      res_load = 1'b1;
    end else if (cmd.result_take) begin
      res_load              = 1'b1;
      res_next.interp_ok    = 1'b1;
      res_next.weight_total = wsum;
      if (neg_r) begin
        res_next.interp_value = (quo > ACC_W'(2 ** (VAL_W - 1))) ? VAL_MIN :
                                $signed(-quo[VAL_W-1:0]);
      end else begin
        res_next.interp_value = (quo > ACC_W'(VAL_MAX)) ? VAL_MAX :
                                $signed(quo[VAL_W-1:0]);
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) result <= res_next;
  end

  // Status to the controller.
  always_comb begin
    sts             = '0;
    sts.clr_last    = &clr_addr;
    sts.is_query    = (item.operation == OP_QUERY);
    sts.single      = (n8 <= 8'd1);
    sts.scan_done   = scan_done;
    sts.t_trivial   = t_trivial;
    sts.div_busy    = div_busy;
    sts.ax_last     = (ax == 2'd2);
    sts.corner_last = (c == 3'd7);
    sts.wsum_zero   = (wsum == '0);
    sts.out_free    = !result_valid || !result_stall;
  end

endmodule

// ===== src/masked_trilinear_grid_interpolator_top.sv =====
// Masked trilinear grid interpolator over a 3-D table with a populated map.
// After reset the block clears the populated map and takes no request meanwhile;
// count registers may still be written. An axis or grid write completes in the
// cycle it is taken and its result appears on the next cycle. A query runs a
// bracket search on each of the three axes (a single-point axis skips it), then
// the eight corner sums and the normalization. Its duration is set by the linear
// scan of the axis memory and by the shared serial divider, which is used for
// each of up to four divisions.
// Depends on mtgi_pkg, mtgi_ctrl and mtgi_datapath.
module masked_trilinear_grid_interpolator_top import mtgi_pkg::*; #(
  parameter int AXIS_POINTS = MTGI_AXIS_POINTS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  item_t                item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data
);

  cmd_t    cmd;
  status_t sts;

  // Count registers accept a write in any cycle.
  assign cfg_ready = 1'b1;

  mtgi_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  mtgi_datapath #(
    .AXIS_POINTS (AXIS_POINTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== src/mtgi_checker.sv =====
// Port-level checks for the interpolator and the bind that attaches them.
// Depends on mtgi_pkg and the top level's ports.
module mtgi_checker import mtgi_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_stall,
  input item_t   item,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");

  // A write request answers on the next cycle with zero value and weight.
  a_write_resp: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && (item.operation != OP_QUERY)) |=>
    (result_valid && (result.interp_value == '0) && (result.weight_total == '0)))
    else $error("write request result missing or nonzero");

  // A failed request carries all-zero fields.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.interp_ok) |->
    ((result.interp_value == '0) && (result.weight_total == '0)))
    else $error("failed result has nonzero fields");

  // Used weight sum never exceeds one.
  a_wsum_max: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.weight_total <= W_ONE))
    else $error("weight total above one");

endmodule

bind masked_trilinear_grid_interpolator_top mtgi_checker u_mtgi_checker (.*);
